// ===== rtl/asrv_pkg.sv =====
// Package: shared constants, types and the CRC-32 byte step for the slot record validator.
`default_nettype none

package asrv_pkg;

  // Largest payload the block accepts, in bytes.
  localparam int PAYLOAD_LIMIT = 128;
  localparam int HEADER_BYTES  = 21;
  localparam int HCRC_SPAN     = 16;

  // Byte position counter: idle (0) up to the last payload byte.
  localparam int POS_W = $clog2(HEADER_BYTES + PAYLOAD_LIMIT + 1);
  typedef logic [POS_W-1:0] pos_t;

  localparam pos_t POS_MAGIC_END  = pos_t'(3);
  localparam pos_t POS_SCHEMA_END = pos_t'(5);
  localparam pos_t POS_GEN_END    = pos_t'(9);
  localparam pos_t POS_LEN_END    = pos_t'(11);
  localparam pos_t POS_PCRC_END   = pos_t'(15);
  localparam pos_t POS_HCRC_END   = pos_t'(19);
  localparam pos_t POS_COMMIT     = pos_t'(HEADER_BYTES - 1);
  localparam pos_t POS_HDR_BYTES  = pos_t'(HEADER_BYTES);
  localparam pos_t POS_HCRC_SPAN  = pos_t'(HCRC_SPAN);
  localparam pos_t POS_MAX        = pos_t'(HEADER_BYTES + PAYLOAD_LIMIT);

  localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
  localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;

  // Register reset values
  localparam logic [31:0] MAGIC_RESET  = 32'h455A_4631;
  localparam logic [15:0] SCHEMA_RESET = 16'd1;
  localparam logic [7:0]  MAXLEN_RESET = 8'd128;
  localparam logic [7:0]  COMMIT_RESET = 8'h3F;

  // Configuration register indexes
  localparam int CFG_IDX_W = 2;
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MAGIC  = 2'd0,
    CFG_SCHEMA = 2'd1,
    CFG_MAXLEN = 2'd2,
    CFG_COMMIT = 2'd3
  } cfg_idx_t;

  typedef enum logic [2:0] {
    ERR_OK          = 3'd0,
    ERR_MAGIC       = 3'd1,
    ERR_SCHEMA      = 3'd2,
    ERR_LENGTH      = 3'd3,
    ERR_UNCOMMITTED = 3'd4,
    ERR_HEADER_CRC  = 3'd5,
    ERR_PAYLOAD_CRC = 3'd6
  } err_t;

  // Slot table update at the end of a record
  typedef struct packed {
    logic        en;
    logic        slot;
    logic        ok;
    logic [31:0] generation;
  } slot_upd_t;

  // Newest valid slot
  typedef struct packed {
    logic        valid;
    logic        slot;
    logic [31:0] generation;
  } winner_t;

  // Reflected CRC-32, one byte.
  function automatic logic [31:0] crc32_byte(input logic [31:0] c, input logic [7:0] b);
    logic [31:0] r;
    r = c ^ {24'h0, b};
    for (int i = 0; i < 8; i++) begin
      r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/asrv_in_if.sv =====
// Interface: record byte channel (valid/ready plus byte, start mark and slot).
`default_nettype none

interface asrv_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       first;
  logic       slot;

  modport source(output valid, data_byte, first, slot, input ready);
  modport sink(input valid, data_byte, first, slot, output ready);
endinterface

`default_nettype wire

// ===== rtl/asrv_out_if.sv =====
// Interface: result channel (valid/ready plus pass-through byte, verdict and winner).
`default_nettype none

interface asrv_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  payload_byte;
  logic        payload_strobe;
  logic        record_done;
  logic        record_ok;
  logic [2:0]  error_code;
  logic        record_slot;
  logic [31:0] record_generation;
  logic [15:0] payload_length;
  logic        winner_valid;
  logic        winner_slot;
  logic [31:0] winner_generation;

  modport source(output valid, payload_byte, payload_strobe, record_done, record_ok,
                 error_code, record_slot, record_generation, payload_length,
                 winner_valid, winner_slot, winner_generation, input ready);
  modport sink(input valid, payload_byte, payload_strobe, record_done, record_ok,
               error_code, record_slot, record_generation, payload_length,
               winner_valid, winner_slot, winner_generation, output ready);
endinterface

`default_nettype wire

// ===== rtl/asrv_slots.sv =====
// Module: two-entry slot table and newest-valid-slot selection.
`default_nettype none

module asrv_slots
  import asrv_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire slot_upd_t upd,
  output winner_t        win_next
);

  logic [1:0]  slot_valid;
  logic [31:0] slot_generation [2];
  logic [1:0]  slot_valid_next;
  logic [31:0] slot_generation_next [2];
  logic        w1;

  always_comb begin
    slot_valid_next      = slot_valid;
    slot_generation_next = slot_generation;
    if (upd.en) begin
      slot_valid_next[upd.slot]      = upd.ok;
      slot_generation_next[upd.slot] = upd.ok ? upd.generation : 32'h0;
    end
  end

  // Slot 1 wins only when slot 0 is not valid or slot 1 is strictly newer.
  always_comb begin
    w1 = slot_valid_next[1] &&
         (!slot_valid_next[0] || (slot_generation_next[1] > slot_generation_next[0]));
    win_next.valid      = slot_valid_next[0] | slot_valid_next[1];
    win_next.slot       = w1;
    win_next.generation = w1 ? slot_generation_next[1] :
                          (slot_valid_next[0] ? slot_generation_next[0] : 32'h0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_valid         <= 2'b00;
      slot_generation[0] <= 32'h0;
      slot_generation[1] <= 32'h0;
    end else begin
      slot_valid         <= slot_valid_next;
      slot_generation[0] <= slot_generation_next[0];
      slot_generation[1] <= slot_generation_next[1];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/ab_slot_record_validator.sv =====
// Top level: A/B slot record validator with CRC-32 header and payload checks.
//
// Usage:
//   rd_bytes carries one record byte per beat, as read from flash. Mark the
//   first header byte with first = 1 and give the slot there; later bytes
//   follow with first = 0. Bytes seen while no record is open are ignored.
//   Every accepted beat produces exactly one beat on report: payload bytes
//   come back with payload_strobe set, the byte that ends a record carries
//   record_done with the verdict, and every beat carries the newest valid
//   slot (winner_*), already updated by a verdict in that same beat.
//   The result is registered: report.valid rises in the cycle after accept.
//   Throughput is one byte per cycle while report is not stalled, limited by the
//   eight-bit unrolled CRC step between the input handshake and the result register.
//   When report stalls, the result register holds and rd_bytes.ready drops
//   until the register is taken; a beat is accepted in the same cycle that
//   the pending result leaves.
//   Reset (rst, synchronous) clears the open record, both slot entries and
//   loads the register defaults. Write cfg_* only while the block is idle.
`default_nettype none

module ab_slot_record_validator
  import asrv_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  asrv_in_if.sink                   rd_bytes,
  asrv_out_if.source                report,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [31:0]          cfg_data
);

  // Configuration registers
  logic [31:0] expected_magic;
  logic [15:0] expected_schema;
  logic [7:0]  max_length;
  logic [7:0]  commit_marker;

  // Record parse state
  pos_t        byte_position, byte_position_next;
  logic [23:0] header_shift, header_shift_next;
  logic [31:0] field_magic, field_magic_next;
  logic [15:0] field_schema, field_schema_next;
  logic [31:0] field_generation, field_generation_next;
  logic [15:0] field_length, field_length_next;
  logic [31:0] field_payload_crc, field_payload_crc_next;
  logic [31:0] running_crc, running_crc_next;
  logic        header_crc_ok, header_crc_ok_next;
  logic        current_slot, current_slot_next;

  // Result register
  logic        out_valid;
  logic [7:0]  res_payload_byte;
  logic        res_strobe;
  logic        res_done;
  err_t        res_code;
  logic        res_slot;
  logic [31:0] res_generation;
  logic [15:0] res_length;
  winner_t     res_winner;

  logic        accept;
  logic        active;
  pos_t        idx;
  logic [31:0] crc_in;
  logic [31:0] crc_upd;
  logic [31:0] shift_word;
  logic        strobe;
  logic        done;
  err_t        code;
  err_t        end_code;
  slot_upd_t   upd;
  winner_t     win_next;

  // Take a beat whenever the result register is free or being emptied.
  assign rd_bytes.ready = !out_valid || report.ready;
  assign accept         = rd_bytes.valid && rd_bytes.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      expected_magic  <= MAGIC_RESET;
      expected_schema <= SCHEMA_RESET;
      max_length      <= MAXLEN_RESET;
      commit_marker   <= COMMIT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_MAGIC:  expected_magic  <= cfg_data;
        CFG_SCHEMA: expected_schema <= cfg_data[15:0];
        CFG_MAXLEN: max_length      <= cfg_data[7:0];
        CFG_COMMIT: commit_marker   <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // A start mark restarts the record at position zero with a fresh CRC.
  assign active     = rd_bytes.first || (byte_position != '0);
  assign idx        = rd_bytes.first ? '0 : byte_position;
  assign crc_in     = rd_bytes.first ? CRC_INIT : running_crc;
  assign crc_upd    = crc32_byte(crc_in, rd_bytes.data_byte);
  assign shift_word = {rd_bytes.data_byte, header_shift};
  // Verdict once the header is accepted: header CRC first, then payload CRC.
  assign end_code   = !header_crc_ok ? ERR_HEADER_CRC :
                      ((~crc_upd) != field_payload_crc ? ERR_PAYLOAD_CRC : ERR_OK);

  always_comb begin
    byte_position_next     = byte_position;
    header_shift_next      = header_shift;
    field_magic_next       = field_magic;
    field_schema_next      = field_schema;
    field_generation_next  = field_generation;
    field_length_next      = field_length;
    field_payload_crc_next = field_payload_crc;
    running_crc_next       = running_crc;
    header_crc_ok_next     = header_crc_ok;
    current_slot_next      = rd_bytes.first ? rd_bytes.slot : current_slot;
    strobe                 = 1'b0;
    done                   = 1'b0;
    code                   = ERR_OK;

    if (active) begin
      byte_position_next = idx + pos_t'(1);
      if (idx < POS_HDR_BYTES) begin
        header_shift_next = shift_word[31:8];
        if (idx < POS_HCRC_SPAN) begin
          running_crc_next = crc_upd;
        end
        case (idx)
          POS_MAGIC_END:  field_magic_next       = shift_word;
          POS_SCHEMA_END: field_schema_next      = shift_word[31:16];
          POS_GEN_END:    field_generation_next  = shift_word;
          POS_LEN_END:    field_length_next      = shift_word[31:16];
          POS_PCRC_END:   field_payload_crc_next = shift_word;
          POS_HCRC_END: begin
            header_crc_ok_next = ((~crc_in) == shift_word);
            running_crc_next   = CRC_INIT;
          end
          POS_COMMIT: begin
            // Check in order; the first failure, or an empty payload, ends the record here.
            done = 1'b1;
            if (field_magic != expected_magic) begin
              code = ERR_MAGIC;
            end else if (field_schema != expected_schema) begin
              code = ERR_SCHEMA;
            end else if ((field_length > {8'h0, max_length}) ||
                         (field_length > 16'(PAYLOAD_LIMIT))) begin
              code = ERR_LENGTH;
            end else if (rd_bytes.data_byte != commit_marker) begin
              code = ERR_UNCOMMITTED;
            end else if (field_length == 16'h0) begin
              // Empty payload: CRC of nothing, running value still initial.
              code = !header_crc_ok ? ERR_HEADER_CRC :
                     ((~crc_in) != field_payload_crc ? ERR_PAYLOAD_CRC : ERR_OK);
            end else begin
              done = 1'b0;
            end
          end
          default: ;
        endcase
      end else begin
        // Payload: pass the byte through and fold it into the payload CRC.
        strobe           = 1'b1;
        running_crc_next = crc_upd;
        if (16'(idx - POS_COMMIT) >= field_length) begin
          done = 1'b1;
          code = end_code;
        end
      end
      if (done) begin
        byte_position_next = '0;
      end
    end
  end

  always_comb begin
    upd.en         = accept && done;
    upd.slot       = current_slot_next;
    upd.ok         = (code == ERR_OK);
    upd.generation = field_generation;
  end

  asrv_slots u_slots (
    .clk      (clk),
    .rst      (rst),
    .upd      (upd),
    .win_next (win_next)
  );

  // Advance parse state on every accepted beat.
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position <= '0;
      running_crc   <= CRC_INIT;
      header_crc_ok <= 1'b0;
      current_slot  <= 1'b0;
    end else if (accept) begin
      byte_position <= byte_position_next;
      running_crc   <= running_crc_next;
      header_crc_ok <= header_crc_ok_next;
      current_slot  <= current_slot_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      header_shift      <= header_shift_next;
      field_magic       <= field_magic_next;
      field_schema      <= field_schema_next;
      field_generation  <= field_generation_next;
      field_length      <= field_length_next;
      field_payload_crc <= field_payload_crc_next;
    end
  end

  // Result register: load on accept, drop valid once taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (report.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      res_payload_byte <= strobe ? rd_bytes.data_byte : 8'h0;
      res_strobe       <= strobe;
      res_done         <= done;
      res_code         <= done ? code : ERR_OK;
      res_slot         <= done ? current_slot_next : 1'b0;
      res_generation   <= done ? field_generation : 32'h0;
      res_length       <= done ? field_length : 16'h0;
      res_winner       <= win_next;
    end
  end

  assign report.valid             = out_valid;
  assign report.payload_byte      = res_payload_byte;
  assign report.payload_strobe    = res_strobe;
  assign report.record_done       = res_done;
  assign report.record_ok         = res_done && (res_code == ERR_OK);
  assign report.error_code        = res_code;
  assign report.record_slot       = res_slot;
  assign report.record_generation = res_generation;
  assign report.payload_length    = res_length;
  assign report.winner_valid      = res_winner.valid;
  assign report.winner_slot       = res_winner.slot;
  assign report.winner_generation = res_winner.generation;

`ifndef SYNTHESIS
  // A verdict on a payload byte can only come from a CRC check.
  a_payload_verdict: assert property (@(posedge clk) disable iff (rst)
    (out_valid && res_strobe && res_done) |->
      (res_code == ERR_OK || res_code == ERR_HEADER_CRC || res_code == ERR_PAYLOAD_CRC))
    else $error("early header failure reported on a payload byte");

  a_no_winner_gen: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !res_winner.valid) |-> (res_winner.generation == 32'h0))
    else $error("winner generation set with no valid slot");

  a_pos_bound: assert property (@(posedge clk) disable iff (rst)
    byte_position <= POS_MAX)
    else $error("byte position ran past the largest record");

  // A record ending always returns the parser to idle.
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    (accept && done) |=> (byte_position == '0))
    else $error("parser not idle after a verdict");
`endif

endmodule

`default_nettype wire
